/* src/fcfa_pkg.sv */
// shared types and constants for the fixed-cell free-list allocator
package fcfa_pkg;

  localparam int MAX_CELLS = 64;
  localparam int IDX_W     = 6;
  localparam int LINK_W    = 7;
  localparam int CNT_W     = 7;
  localparam int BYTES_W   = 13;
  localparam int OFS_W     = 18;
  localparam int ADDR_W    = 3;

  localparam logic [CNT_W-1:0]   RST_CELLS = 7'd64;
  localparam logic [BYTES_W-1:0] RST_BYTES = 13'd8;
  localparam logic [BYTES_W-1:0] MAX_BYTES = 13'd4096;

  // register indexes, decoded from paddr[2]
  localparam logic REG_CELLS = 1'b0;
  localparam logic REG_BYTES = 1'b1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [1:0] ST_NONE_LIVE = 2'd3;

  typedef struct packed {
    logic               reinit;
    logic [CNT_W-1:0]   reinit_cells;
    logic [CNT_W-1:0]   cells_in_use;
    logic [BYTES_W-1:0] cell_bytes;
  } cfg_t;

endpackage

/* src/fixed_cell_free_list_allocator_core.sv */
// top level: request control, counters and result registers of the free-list allocator
//
// For each request, the accepting edge reads the next link of the list head from the
// link memory, busy is high for one cycle while the request is resolved, and the edge
// ending that cycle updates the list and registers the result, which appears with
// out_valid for the following cycle. Because of the synchronous read of the link
// memory, no new request is taken while busy is high. The result
// cannot be held off by the receiver. After reset, or after a write to the pool size
// register, the list is linked in index order at once; there is no clearing pass.
module fixed_cell_free_list_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [5:0]                   in_cell_index,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [5:0]                   out_granted_index,
  output logic [17:0]                  out_byte_offset,
  output logic [6:0]                   out_live_count,
  output logic [6:0]                   out_free_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  fcfa_pkg::cfg_t cfg;

  logic state_r, state_nxt;
  logic op_r;
  logic [fcfa_pkg::IDX_W-1:0]  idx_r;
  logic [fcfa_pkg::LINK_W-1:0] head_r, head_nxt;
  logic [fcfa_pkg::CNT_W-1:0]  live_r, live_nxt;
  logic [fcfa_pkg::CNT_W-1:0]  free_r, free_nxt;
  logic [fcfa_pkg::LINK_W-1:0] link_rd;
  logic                        accept;
  logic                        alloc_ok;
  logic                        free_ok;
  logic                        wr_en;
  logic [1:0]                  status;
  logic [fcfa_pkg::IDX_W+fcfa_pkg::BYTES_W-1:0] product;

  logic                       out_valid_r;
  logic [1:0]                 status_r;
  logic [fcfa_pkg::IDX_W-1:0] granted_r;
  logic [fcfa_pkg::OFS_W-1:0] offset_r;

  fcfa_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = (state_r == S_EXEC);
  assign accept = start & ~busy;

  fcfa_link_mem u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg.reinit),
    .rd_en   (accept),
    .rd_addr (head_r[fcfa_pkg::IDX_W-1:0]),
    .rd_data (link_rd),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (head_r)
  );

  always_comb begin
    alloc_ok = busy && (op_r == fcfa_pkg::OP_ALLOC) && (free_r != '0)
               && (head_r < cfg.cells_in_use);
    free_ok  = busy && (op_r == fcfa_pkg::OP_FREE)
               && ({1'b0, idx_r} < cfg.cells_in_use) && (live_r != '0);
    wr_en    = free_ok;
    product  = {{fcfa_pkg::BYTES_W{1'b0}}, head_r[fcfa_pkg::IDX_W-1:0]}
               * {{fcfa_pkg::IDX_W{1'b0}}, cfg.cell_bytes};

    if (op_r == fcfa_pkg::OP_ALLOC) begin
      status = alloc_ok ? fcfa_pkg::ST_OK : fcfa_pkg::ST_EMPTY;
    end else if ({1'b0, idx_r} >= cfg.cells_in_use) begin
      status = fcfa_pkg::ST_BAD_INDEX;
    end else if (live_r == '0) begin
      status = fcfa_pkg::ST_NONE_LIVE;
    end else begin
      status = fcfa_pkg::ST_OK;
    end

    head_nxt  = head_r;
    live_nxt  = live_r;
    free_nxt  = free_r;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        if (alloc_ok) begin
          head_nxt = link_rd;
          live_nxt = live_r + fcfa_pkg::CNT_W'(1);
          free_nxt = free_r - fcfa_pkg::CNT_W'(1);
        end else if (free_ok) begin
          head_nxt = {1'b0, idx_r};
          live_nxt = live_r - fcfa_pkg::CNT_W'(1);
          free_nxt = free_r + fcfa_pkg::CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      live_r      <= '0;
      free_r      <= fcfa_pkg::RST_CELLS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (cfg.reinit) begin
        head_r <= '0;
        live_r <= '0;
        free_r <= cfg.reinit_cells;
      end else begin
        head_r <= head_nxt;
        live_r <= live_nxt;
        free_r <= free_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      idx_r <= in_cell_index;
    end
    if (busy) begin
      status_r  <= status;
      granted_r <= alloc_ok ? head_r[fcfa_pkg::IDX_W-1:0] : '0;
      offset_r  <= alloc_ok ? product[fcfa_pkg::OFS_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = granted_r;
  assign out_byte_offset   = offset_r;
  assign out_live_count    = live_r;
  assign out_free_count    = free_r;

  // live plus free always equals the pool size
  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, live_r} + {1'b0, free_r}) == {1'b0, cfg.cells_in_use})
    else $error("live and free counts do not add up to the pool size");

  assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("request resolve lasted more than one cycle");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a resolved request");

  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (op_r == fcfa_pkg::OP_FREE) && (live_r != '0))
    else $error("link memory written outside a valid free");

endmodule

/* src/fcfa_cfg_regs.sv */
// configuration registers behind the apb-style port
module fcfa_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fcfa_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output fcfa_pkg::cfg_t               cfg
);

  logic [fcfa_pkg::CNT_W-1:0]   cells_r;
  logic [fcfa_pkg::BYTES_W-1:0] bytes_r;
  logic [fcfa_pkg::CNT_W-1:0]   cells_sat;
  logic [fcfa_pkg::BYTES_W-1:0] bytes_sat;
  logic                         wr_cells;
  logic                         wr_bytes;

  assign pready   = 1'b1;
  assign wr_cells = psel & penable & pwrite & (paddr[2] == fcfa_pkg::REG_CELLS);
  assign wr_bytes = psel & penable & pwrite & (paddr[2] == fcfa_pkg::REG_BYTES);

  always_comb begin
    cells_sat = pwdata[fcfa_pkg::CNT_W-1:0];
    if (cells_sat == '0) begin
      cells_sat = fcfa_pkg::CNT_W'(1);
    end else if (cells_sat > fcfa_pkg::CNT_W'(fcfa_pkg::MAX_CELLS)) begin
      cells_sat = fcfa_pkg::CNT_W'(fcfa_pkg::MAX_CELLS);
    end
    bytes_sat = pwdata[fcfa_pkg::BYTES_W-1:0];
    if (bytes_sat > fcfa_pkg::MAX_BYTES) begin
      bytes_sat = fcfa_pkg::MAX_BYTES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= fcfa_pkg::RST_CELLS;
      bytes_r <= fcfa_pkg::RST_BYTES;
    end else begin
      if (wr_cells) begin
        cells_r <= cells_sat;
      end
      if (wr_bytes) begin
        bytes_r <= bytes_sat;
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      fcfa_pkg::REG_CELLS: prdata = {{(32-fcfa_pkg::CNT_W){1'b0}}, cells_r};
      default:             prdata = {{(32-fcfa_pkg::BYTES_W){1'b0}}, bytes_r};
    endcase
  end

  // a pool size write relinks the pool at the same edge
  assign cfg.reinit       = wr_cells;
  assign cfg.reinit_cells = cells_sat;
  assign cfg.cells_in_use = cells_r;
  assign cfg.cell_bytes   = bytes_r;

endmodule

/* src/fcfa_link_mem.sv */
// next-link memory with per-entry valid bits; an unwritten entry reads as its index plus one
module fcfa_link_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [fcfa_pkg::IDX_W-1:0]  rd_addr,
  output logic [fcfa_pkg::LINK_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [fcfa_pkg::IDX_W-1:0]  wr_addr,
  input  logic [fcfa_pkg::LINK_W-1:0] wr_data
);

  logic [fcfa_pkg::LINK_W-1:0] mem [fcfa_pkg::MAX_CELLS];
  logic [fcfa_pkg::MAX_CELLS-1:0] valid_r;
  logic [fcfa_pkg::LINK_W-1:0] rd_mem_r;
  logic                        rd_valid_r;
  logic [fcfa_pkg::IDX_W-1:0]  rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r  <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_mem_r
                              : ({1'b0, rd_addr_r} + fcfa_pkg::LINK_W'(1));

endmodule
